### rtl/core/cau_pkg.sv
// Shared types and constants for the complex arithmetic unit.
// No dependencies.
package cau_pkg;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } mode_t;

    // Quotient bits kept by the divider: 33 value bits plus one overflow bit.
    localparam int CAU_QW        = 34;
    localparam int CAU_DIV_STEPS = 34;
    // Accept edge to the edge that takes the result.
    localparam int CAU_LATENCY   = 39;

    // Control that travels beside the data through prep and divider stages.
    typedef struct packed {
        logic valid;
        logic is_div;
        logic dz;
        logic neg_re;
        logic neg_im;
    } cau_ctrl_t;

endpackage

### rtl/core/cau_mult.sv
// Product and sum stages: four cross products, two squares, then the
// combined sums for every mode. Depends on cau_pkg.
module cau_mult (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  cau_pkg::mode_t      in_mode,
    input  logic signed [31:0]  a_re,
    input  logic signed [31:0]  a_im,
    input  logic signed [31:0]  b_re,
    input  logic signed [31:0]  b_im,
    output logic                out_valid,
    output cau_pkg::mode_t      out_mode,
    output logic signed [64:0]  sum_re,
    output logic signed [64:0]  sum_im,
    output logic [63:0]         den
);
    import cau_pkg::*;

    logic               p_valid_reg;
    mode_t              p_mode_reg;
    logic signed [63:0] p_ac_reg, p_bd_reg, p_ad_reg, p_bc_reg;
    logic signed [63:0] p_cc_reg, p_dd_reg;
    logic signed [32:0] p_sre_reg, p_sim_reg;

    logic               s_valid_reg;
    mode_t              s_mode_reg;
    logic signed [64:0] s_re_reg, s_im_reg;
    logic [63:0]        s_den_reg;

    logic signed [64:0] s_re_next, s_im_next;
    logic signed [32:0] as_re, as_im;

    assign as_re = (in_mode == MODE_SUB) ? (33'(a_re) - 33'(b_re)) : (33'(a_re) + 33'(b_re));
    assign as_im = (in_mode == MODE_SUB) ? (33'(a_im) - 33'(b_im)) : (33'(a_im) + 33'(b_im));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= in_valid;
            s_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_mode_reg <= in_mode;
        p_ac_reg   <= 64'(a_re) * 64'(b_re);
        p_bd_reg   <= 64'(a_im) * 64'(b_im);
        p_ad_reg   <= 64'(a_re) * 64'(b_im);
        p_bc_reg   <= 64'(a_im) * 64'(b_re);
        p_cc_reg   <= 64'(b_re) * 64'(b_re);
        p_dd_reg   <= 64'(b_im) * 64'(b_im);
        p_sre_reg  <= as_re;
        p_sim_reg  <= as_im;
    end

    always_comb
    begin
        unique case (p_mode_reg)
            MODE_MUL:
            begin
                s_re_next = 65'(p_ac_reg) - 65'(p_bd_reg);
                s_im_next = 65'(p_ad_reg) + 65'(p_bc_reg);
            end
            MODE_DIV:
            begin
                s_re_next = 65'(p_ac_reg) + 65'(p_bd_reg);
                s_im_next = 65'(p_bc_reg) - 65'(p_ad_reg);
            end
            default:
            begin
                s_re_next = 65'(p_sre_reg);
                s_im_next = 65'(p_sim_reg);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s_mode_reg <= p_mode_reg;
        s_re_reg   <= s_re_next;
        s_im_reg   <= s_im_next;
        // both squares are nonnegative, sum stays within 2^63
        s_den_reg  <= 64'(p_cc_reg) + 64'(p_dd_reg);
    end

    assign out_valid = s_valid_reg;
    assign out_mode  = s_mode_reg;
    assign sum_re    = s_re_reg;
    assign sum_im    = s_im_reg;
    assign den       = s_den_reg;

endmodule

### rtl/core/cau_prep.sv
// Sign/magnitude split and alignment of the operands for the divider
// chain. Depends on cau_pkg.
module cau_prep #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  cau_pkg::mode_t             in_mode,
    input  logic signed [64:0]         sum_re,
    input  logic signed [64:0]         sum_im,
    input  logic [63:0]                in_den,
    output cau_pkg::cau_ctrl_t         ctrl,
    output logic [97+FRAC_BITS-1:0]    rem_re,
    output logic [97+FRAC_BITS-1:0]    rem_im,
    output logic [63:0]                den
);
    import cau_pkg::*;

    localparam int RW = 97 + FRAC_BITS;

    logic        valid_reg;
    cau_ctrl_t   ctrl_next, ctrl_data_reg;
    logic [RW-1:0] rem_re_reg, rem_im_reg, rem_re_next, rem_im_next;
    logic [63:0] den_reg;
    logic [63:0] mag_re, mag_im;
    logic [64:0] neg_re_v, neg_im_v;

    assign neg_re_v = 65'(0) - sum_re;
    assign neg_im_v = 65'(0) - sum_im;
    assign mag_re   = sum_re[64] ? neg_re_v[63:0] : sum_re[63:0];
    assign mag_im   = sum_im[64] ? neg_im_v[63:0] : sum_im[63:0];

    always_comb
    begin
        ctrl_next.valid  = in_valid;
        ctrl_next.is_div = (in_mode == MODE_DIV);
        ctrl_next.dz     = (in_mode == MODE_DIV) && (in_den == 64'd0);
        ctrl_next.neg_re = sum_re[64];
        ctrl_next.neg_im = sum_im[64];
        unique case (in_mode)
            MODE_DIV:
            begin
                rem_re_next = RW'(mag_re) << FRAC_BITS;
                rem_im_next = RW'(mag_im) << FRAC_BITS;
            end
            MODE_MUL:
            begin
                rem_re_next = RW'(mag_re >> FRAC_BITS);
                rem_im_next = RW'(mag_im >> FRAC_BITS);
            end
            default:
            begin
                rem_re_next = RW'(mag_re);
                rem_im_next = RW'(mag_im);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        ctrl_data_reg <= ctrl_next;
        rem_re_reg    <= rem_re_next;
        rem_im_reg    <= rem_im_next;
        den_reg       <= in_den;
    end

    always_comb
    begin
        ctrl       = ctrl_data_reg;
        ctrl.valid = valid_reg;
    end

    assign rem_re = rem_re_reg;
    assign rem_im = rem_im_reg;
    assign den    = den_reg;

endmodule

### rtl/core/cau_div_step.sv
// One restoring-division stage: decides quotient bit STEP for both parts.
// Non-divide transactions pass through untouched. Depends on cau_pkg.
module cau_div_step #(
    parameter int FRAC_BITS = 16,
    parameter int STEP      = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cau_pkg::cau_ctrl_t             in_ctrl,
    input  logic [97+FRAC_BITS-1:0]        in_rem_re,
    input  logic [97+FRAC_BITS-1:0]        in_rem_im,
    input  logic [cau_pkg::CAU_QW-1:0]     in_q_re,
    input  logic [cau_pkg::CAU_QW-1:0]     in_q_im,
    input  logic [63:0]                    in_den,
    output cau_pkg::cau_ctrl_t             out_ctrl,
    output logic [97+FRAC_BITS-1:0]        out_rem_re,
    output logic [97+FRAC_BITS-1:0]        out_rem_im,
    output logic [cau_pkg::CAU_QW-1:0]     out_q_re,
    output logic [cau_pkg::CAU_QW-1:0]     out_q_im,
    output logic [63:0]                    out_den
);
    import cau_pkg::*;

    localparam int RW = 97 + FRAC_BITS;

    logic          valid_reg;
    cau_ctrl_t     ctrl_reg;
    logic [RW-1:0] dsh, rem_re_reg, rem_im_reg, rem_re_next, rem_im_next;
    logic [CAU_QW-1:0] q_re_reg, q_im_reg, q_re_next, q_im_next;
    logic [63:0]   den_reg;
    logic          act, ge_re, ge_im;

    assign dsh   = RW'(in_den) << STEP;
    assign act   = in_ctrl.is_div && !in_ctrl.dz;
    assign ge_re = act && (in_rem_re >= dsh);
    assign ge_im = act && (in_rem_im >= dsh);

    always_comb
    begin
        rem_re_next = ge_re ? (in_rem_re - dsh) : in_rem_re;
        rem_im_next = ge_im ? (in_rem_im - dsh) : in_rem_im;
        q_re_next   = in_q_re;
        q_im_next   = in_q_im;
        q_re_next[STEP] = ge_re;
        q_im_next[STEP] = ge_im;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_ctrl.valid;
    end

    always_ff @(posedge clk)
    begin
        ctrl_reg   <= in_ctrl;
        rem_re_reg <= rem_re_next;
        rem_im_reg <= rem_im_next;
        q_re_reg   <= q_re_next;
        q_im_reg   <= q_im_next;
        den_reg    <= in_den;
    end

    always_comb
    begin
        out_ctrl       = ctrl_reg;
        out_ctrl.valid = valid_reg;
    end

    assign out_rem_re = rem_re_reg;
    assign out_rem_im = rem_im_reg;
    assign out_q_re   = q_re_reg;
    assign out_q_im   = q_im_reg;
    assign out_den    = den_reg;

endmodule

### rtl/core/complex_arith_unit.sv
// Top level of the complex arithmetic unit: input register, product and
// prep stages, divider chain, saturation. Depends on cau_pkg and submodules.
//
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------
//  command   | start, busy        | mode, a_re, a_im, b_re, b_im
//  result    | done (strobe)      | res_re, res_im, overflow, div_zero
//
// One transaction per cycle; busy is never raised.
// Every mode takes the same path: input, product, sum and prep stages,
// 34 restoring-division stages (one quotient bit each) and the output register.
// Reset clears all valid bits; payload registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
module complex_arith_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic signed [31:0] a_re,
    input  logic signed [31:0] a_im,
    input  logic signed [31:0] b_re,
    input  logic signed [31:0] b_im,
    output logic               done,
    output logic signed [31:0] res_re,
    output logic signed [31:0] res_im,
    output logic               overflow,
    output logic               div_zero
);
    import cau_pkg::*;

    localparam int RW = 97 + FRAC_BITS;

    logic               in_valid_reg;
    mode_t              in_mode_reg;
    logic signed [31:0] in_a_re_reg, in_a_im_reg, in_b_re_reg, in_b_im_reg;

    logic               m_valid;
    mode_t              m_mode;
    logic signed [64:0] m_sum_re, m_sum_im;
    logic [63:0]        m_den;

    cau_ctrl_t         ctrl_s   [0:CAU_DIV_STEPS];
    logic [RW-1:0]     rem_re_s [0:CAU_DIV_STEPS];
    logic [RW-1:0]     rem_im_s [0:CAU_DIV_STEPS];
    logic [CAU_QW-1:0] q_re_s   [0:CAU_DIV_STEPS];
    logic [CAU_QW-1:0] q_im_s   [0:CAU_DIV_STEPS];
    logic [63:0]       den_s    [0:CAU_DIV_STEPS];

    cau_ctrl_t     fc;
    logic [RW-1:0] mag_re, mag_im;
    logic          ovf_re, ovf_im;
    logic [31:0]   val_re, val_im;

    logic        done_reg;
    logic [31:0] res_re_reg, res_im_reg, res_re_next, res_im_next;
    logic        ovf_reg, ovf_next, dz_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        in_mode_reg <= mode_t'(mode);
        in_a_re_reg <= a_re;
        in_a_im_reg <= a_im;
        in_b_re_reg <= b_re;
        in_b_im_reg <= b_im;
    end

    cau_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_mode   (in_mode_reg),
        .a_re      (in_a_re_reg),
        .a_im      (in_a_im_reg),
        .b_re      (in_b_re_reg),
        .b_im      (in_b_im_reg),
        .out_valid (m_valid),
        .out_mode  (m_mode),
        .sum_re    (m_sum_re),
        .sum_im    (m_sum_im),
        .den       (m_den)
    );

    cau_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (m_valid),
        .in_mode  (m_mode),
        .sum_re   (m_sum_re),
        .sum_im   (m_sum_im),
        .in_den   (m_den),
        .ctrl     (ctrl_s[0]),
        .rem_re   (rem_re_s[0]),
        .rem_im   (rem_im_s[0]),
        .den      (den_s[0])
    );

    assign q_re_s[0] = '0;
    assign q_im_s[0] = '0;

    for (genvar g = 0; g < CAU_DIV_STEPS; g++)
    begin : g_div
        cau_div_step #(
            .FRAC_BITS (FRAC_BITS),
            .STEP      (CAU_DIV_STEPS - 1 - g)
        ) u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_ctrl    (ctrl_s[g]),
            .in_rem_re  (rem_re_s[g]),
            .in_rem_im  (rem_im_s[g]),
            .in_q_re    (q_re_s[g]),
            .in_q_im    (q_im_s[g]),
            .in_den     (den_s[g]),
            .out_ctrl   (ctrl_s[g+1]),
            .out_rem_re (rem_re_s[g+1]),
            .out_rem_im (rem_im_s[g+1]),
            .out_q_re   (q_re_s[g+1]),
            .out_q_im   (q_im_s[g+1]),
            .out_den    (den_s[g+1])
        );
    end

    assign fc     = ctrl_s[CAU_DIV_STEPS];
    assign mag_re = fc.is_div ? RW'(q_re_s[CAU_DIV_STEPS]) : rem_re_s[CAU_DIV_STEPS];
    assign mag_im = fc.is_div ? RW'(q_im_s[CAU_DIV_STEPS]) : rem_im_s[CAU_DIV_STEPS];

    // negative side may reach exactly 2^31 without saturating
    assign ovf_re = fc.neg_re ? ((mag_re[RW-1:32] != '0) || (mag_re[31] && mag_re[30:0] != '0))
                              : (mag_re[RW-1:31] != '0);
    assign ovf_im = fc.neg_im ? ((mag_im[RW-1:32] != '0) || (mag_im[31] && mag_im[30:0] != '0))
                              : (mag_im[RW-1:31] != '0);
    assign val_re = fc.neg_re ? (32'd0 - mag_re[31:0]) : mag_re[31:0];
    assign val_im = fc.neg_im ? (32'd0 - mag_im[31:0]) : mag_im[31:0];

    always_comb
    begin
        if (fc.dz)
        begin
            res_re_next = '0;
            res_im_next = '0;
            ovf_next    = 1'b0;
        end
        else
        begin
            res_re_next = ovf_re ? (fc.neg_re ? 32'h8000_0000 : 32'h7FFF_FFFF) : val_re;
            res_im_next = ovf_im ? (fc.neg_im ? 32'h8000_0000 : 32'h7FFF_FFFF) : val_im;
            ovf_next    = ovf_re || ovf_im;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= fc.valid;
    end

    always_ff @(posedge clk)
    begin
        res_re_reg <= res_re_next;
        res_im_reg <= res_im_next;
        ovf_reg    <= ovf_next;
        dz_reg     <= fc.dz;
    end

    assign done     = done_reg;
    assign res_re   = res_re_reg;
    assign res_im   = res_im_reg;
    assign overflow = ovf_reg;
    assign div_zero = dz_reg;

endmodule

### rtl/core/cau_checker.sv
// Port-level checks for complex_arith_unit, attached with a bind.
// Depends on cau_pkg.
module cau_props (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] res_re,
    input logic signed [31:0] res_im,
    input logic               overflow,
    input logic               div_zero
);
    import cau_pkg::*;

    // every accepted transaction comes back after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##CAU_LATENCY done)
        else $error("accepted transaction without result strobe");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && rst_n, CAU_LATENCY))
        else $error("result strobe without accepted transaction");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && div_zero) |-> (res_re == 32'sd0 && res_im == 32'sd0 && !overflow))
        else $error("zero divisor result not cleared");

    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow) |-> (res_re == 32'sh7FFF_FFFF || res_re == 32'sh8000_0000 ||
                                res_im == 32'sh7FFF_FFFF || res_im == 32'sh8000_0000))
        else $error("overflow without a saturated part");

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind complex_arith_unit cau_props u_cau_props (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .res_re   (res_re),
    .res_im   (res_im),
    .overflow (overflow),
    .div_zero (div_zero)
);

### sim/cau_checker.sv
// Checker for the complex arithmetic unit: watches the command and result
// channels, predicts each result and compares. Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         mode,
    input  logic signed [31:0] a_re,
    input  logic signed [31:0] a_im,
    input  logic signed [31:0] b_re,
    input  logic signed [31:0] b_im,
    input  logic               done,
    input  logic signed [31:0] res_re,
    input  logic signed [31:0] res_im,
    input  logic               overflow,
    input  logic               div_zero,
    output int                 errors,
    output int                 pending
);
    import cau_pkg::*;

    localparam int FRAC = 16;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               ovf;
        logic               dz;
    } cplx_res_t;

    cplx_res_t expected_q[$];

    // Clamp an exact value to 32-bit signed, flagging saturation.
    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                   inout logic ovf);
        if (v > 128'sd2147483647) begin
            ovf = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -128'sd2147483648) begin
            ovf = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Truncating (toward zero) divide of an exact value.
    function automatic logic signed [127:0] tdiv(input logic signed [127:0] n,
                                                 input logic signed [127:0] d);
        logic [127:0] m;
        logic [127:0] q;
        m = n < 0 ? -n : n;
        q = m / d;
        return n < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic cplx_res_t compute_result(input mode_t op,
        input logic signed [31:0] ar, input logic signed [31:0] ai,
        input logic signed [31:0] br, input logic signed [31:0] bi);
        cplx_res_t r;
        logic signed [127:0] a, b, c, d, den;
        logic o;
        a = ar; b = ai; c = br; d = bi;
        o = 1'b0;
        r = '0;
        case (op)
            MODE_ADD:
            begin
                r.re = clamp32(a + c, o);
                r.im = clamp32(b + d, o);
            end
            MODE_SUB:
            begin
                r.re = clamp32(a - c, o);
                r.im = clamp32(b - d, o);
            end
            MODE_MUL:
            begin
                r.re = clamp32(tdiv(a * c - b * d, 128'sd1 << FRAC), o);
                r.im = clamp32(tdiv(a * d + b * c, 128'sd1 << FRAC), o);
            end
            default:
            begin
                den = c * c + d * d;
                if (den == 0)
                    r.dz = 1'b1;
                else
                begin
                    r.re = clamp32(tdiv((a * c + b * d) <<< FRAC, den), o);
                    r.im = clamp32(tdiv((b * c - a * d) <<< FRAC, den), o);
                end
            end
        endcase
        r.ovf = o;
        return r;
    endfunction

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        cplx_res_t e;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("unexpected result re=%h im=%h", res_re, res_im);
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e.re !== res_re || e.im !== res_im || e.ovf !== overflow
                        || e.dz !== div_zero)
                    begin
                        errors <= errors + 1;
                        if (errors < 10)
                            $display("mismatch: exp %h %h %b %b, got %h %h %b %b",
                                     e.re, e.im, e.ovf, e.dz,
                                     res_re, res_im, overflow, div_zero);
                    end
                end
            end
            if (start && !busy)
                expected_q.push_back(compute_result(mode_t'(mode), a_re, a_im,
                                                    b_re, b_im));
        end
        pending <= expected_q.size();
    end
endmodule

### sim/tb_top.sv
// Top of the complex arithmetic unit testbench: clock, reset, directed and
// random stimulus, verdict. Depends on cau_pkg, complex_arith_unit, cau_checker.
`timescale 1ns / 1ps
module tb_top;
    import cau_pkg::*;

    localparam int N_RANDOM = 1750;
    localparam int MAX_CYCLES = 200000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         mode;
    logic signed [31:0] a_re, a_im, b_re, b_im;
    logic               done;
    logic signed [31:0] res_re, res_im;
    logic               overflow, div_zero;
    int                 errors;
    int                 pending;
    int                 cycle_cnt;

    complex_arith_unit u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .done(done),
        .res_re(res_re), .res_im(res_im), .overflow(overflow),
        .div_zero(div_zero)
    );

    cau_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .done(done),
        .res_re(res_re), .res_im(res_im), .overflow(overflow),
        .div_zero(div_zero), .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt > MAX_CYCLES)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Present one transaction and hold it until accepted.
    task automatic send_cmd(input mode_t op, input logic [31:0] ar,
                            input logic [31:0] ai, input logic [31:0] br,
                            input logic [31:0] bi);
        start <= 1'b1;
        mode  <= op;
        a_re  <= ar;
        a_im  <= ai;
        b_re  <= br;
        b_im  <= bi;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Mix of full-range values, small Q16.16 magnitudes and corner values.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 5))
            0, 1: return $urandom();
            2:    return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF;
            3:    return $signed($urandom_range(0, 32'h7FFFFF)) - 32'sh3FFFFF;
            4:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h80000000;
                    1: return 32'h7FFFFFFF;
                    2: return 32'h00010000;
                    3: return 32'hFFFF0000;
                    default: return 32'h0;
                endcase
            end
            default: return $urandom() >> $urandom_range(0, 31);
        endcase
    endfunction

    initial
    begin
        mode_t op;
        int burst;
        logic [31:0] br, bi;
        start = 1'b0;
        mode  = '0;
        a_re  = '0;
        a_im  = '0;
        b_re  = '0;
        b_im  = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, each op, zero divisor, saturation, exact -2^31.
        for (int m = 0; m < 4; m++)
        begin
            op = mode_t'(m);
            send_cmd(op, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
            send_cmd(op, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
            send_cmd(op, 32'h00010000, 32'hFFFF0000, 32'h00020000, 32'h00008000);
            send_cmd(op, 32'hFFFFFFFF, 32'h00000001, 32'h0, 32'h0);
        end
        send_cmd(MODE_ADD, 32'hC0000000, 32'hC0000000, 32'hC0000000, 32'h0);
        send_cmd(MODE_SUB, 32'h80000000, 32'h0, 32'h7FFFFFFF, 32'h1);
        send_cmd(MODE_MUL, 32'h00010000, 32'hFFFFFFFF, 32'h00000001, 32'h00000001);
        send_cmd(MODE_DIV, 32'h80000000, 32'h0, 32'h00010000, 32'h0);
        send_cmd(MODE_DIV, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00000001, 32'h0);
        send_cmd(MODE_DIV, 32'h00010000, 32'h0, 32'h00000000, 32'h00000001);
        send_cmd(MODE_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);

        // Drain fully once before the random part.
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);

        for (int i = 0; i < N_RANDOM; )
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && i < N_RANDOM; k++, i++)
            begin
                br = pick_operand();
                bi = pick_operand();
                if ($urandom_range(0, 15) == 0)
                begin
                    br = 0;
                    bi = 0;
                end
                send_cmd(mode_t'($urandom_range(0, 3)), pick_operand(),
                         pick_operand(), br, bi);
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 45));
        end

        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (CAU_LATENCY + 5) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
